### rtl/ascii_range_frame_parser_assert.svh
// ----------------------------------------------------------------------------
// ascii_range_frame_parser_assert.svh
// Assertion macros for the rangefinder frame parser; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASCII_RANGE_FRAME_PARSER_ASSERT_SVH
`define ASCII_RANGE_FRAME_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define ARFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ARFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define ARFP_ASSERT(lbl, prop, msg)
`define ARFP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### rtl/arfp_pkg.sv
// ----------------------------------------------------------------------------
// arfp_pkg
// Types and constants shared by the rangefinder frame parser.
// ----------------------------------------------------------------------------
package arfp_pkg;

  localparam int PORT_IN_W  = 3;
  localparam int BYTE_W     = 8;
  localparam int DIST_W     = 17;
  localparam int CONF_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int LEN_W      = 3;
  localparam int DIST_CHARS = 5;
  localparam int CONF_CHARS = 2;

  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;

  localparam logic [DIST_W-1:0] DIST_MIN_RST = 17'd0;
  localparam logic [DIST_W-1:0] DIST_MAX_RST = 17'd99999;
  localparam logic [CONF_W-1:0] CONF_MAX_RST = 7'd99;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIST_MIN = 2'd0,
    CFG_DIST_MAX = 2'd1,
    CFG_CONF_MAX = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_HDR  = 2'd0,
    PH_DIST = 2'd1,
    PH_SEP  = 2'd2,
    PH_CONF = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    SC_WS   = 2'd0,
    SC_DIG  = 2'd1,
    SC_STOP = 2'd2
  } scan_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN_D = 2'd1,
    ST_SCAN_C = 2'd2,
    ST_EMIT   = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    logic take;
    logic start_c;
    logic scan;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_conv;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/arfp_in_if.sv
// ----------------------------------------------------------------------------
// arfp_in_if
// Input channel: one received byte and its port index per word.
// ----------------------------------------------------------------------------
interface arfp_in_if;
  logic                              valid;
  logic                              ready;
  logic [arfp_pkg::PORT_IN_W-1:0]    port;
  logic [arfp_pkg::BYTE_W-1:0]       rx_byte;

  modport source (output valid, output port, output rx_byte, input ready);
  modport sink (input valid, input port, input rx_byte, output ready);
endinterface

### rtl/arfp_out_if.sv
// ----------------------------------------------------------------------------
// arfp_out_if
// Output channel: one parsed range result per word.
// ----------------------------------------------------------------------------
interface arfp_out_if;
  logic                              valid;
  logic                              ready;
  logic [arfp_pkg::PORT_IN_W-1:0]    out_port;
  logic [arfp_pkg::DIST_W-1:0]       distance;
  logic [arfp_pkg::CONF_W-1:0]       confidence;
  logic                              in_range;

  modport source (output valid, output out_port, output distance, output confidence,
                  output in_range, input ready);
  modport sink (input valid, input out_port, input distance, input confidence,
                input in_range, output ready);
endinterface

### rtl/arfp_dp.sv
// ----------------------------------------------------------------------------
// arfp_dp
// Datapath: per-port frame state, byte buffer, serial number scanner,
// limit check and output register.
// ----------------------------------------------------------------------------
module arfp_dp #(
  parameter int PORTS    = 2,
  parameter int BUF_SIZE = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  arfp_pkg::ctrl_cmd_t                  cmd_i,
  output arfp_pkg::dp_status_t                 sts_o,
  input  logic [arfp_pkg::PORT_IN_W-1:0]       port_i,
  input  logic [arfp_pkg::BYTE_W-1:0]          rx_byte_i,
  input  logic                                 cfg_we_i,
  input  logic [arfp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [arfp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [arfp_pkg::PORT_IN_W-1:0]       out_port_o,
  output logic [arfp_pkg::DIST_W-1:0]          distance_o,
  output logic [arfp_pkg::CONF_W-1:0]          confidence_o,
  output logic                                 in_range_o
);

  localparam int PORT_W    = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int IDX_W     = $clog2(BUF_SIZE);
  localparam int CNT_W     = $clog2(BUF_SIZE + 1);
  localparam int ADDR_W    = PORT_W + IDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int DW        = arfp_pkg::DIST_W;
  localparam int LW        = arfp_pkg::LEN_W;

  // configuration
  logic [DW-1:0]                   dist_min_q, dist_max_q;
  logic [arfp_pkg::CONF_W-1:0]     conf_max_q;

  // per-port frame state
  arfp_pkg::phase_e                phase_q [PORTS];
  logic [CNT_W-1:0]                count_q [PORTS];
  logic [IDX_W-1:0]                comma_q [PORTS];

  logic [arfp_pkg::BYTE_W-1:0]     mem [MEM_DEPTH];

  logic [PORT_W-1:0]               pi;
  logic                            port_ok, full, need_conv, wr_en;
  arfp_pkg::phase_e                cur_ph, nx_ph;
  logic [CNT_W-1:0]                cur_cnt, nx_cnt, cnt_inc, cdiff;
  logic [IDX_W-1:0]                cur_cm, nx_cm, cm1, cbase;
  logic [LW-1:0]                   dlen, clen;

  // conversion state
  logic [PORT_W-1:0]               conv_port_q;
  logic [IDX_W-1:0]                c_base_q, base_q;
  logic [LW-1:0]                   c_len_q, len_q, idx_q;
  logic                            rd_en, rd_pend_q;
  logic [ADDR_W-1:0]               rd_addr;
  logic [arfp_pkg::BYTE_W-1:0]     rd_data_q;
  arfp_pkg::scan_e                 sc_st_q, sc_st_d;
  logic [DW-1:0]                   acc_q, acc_d, acc_x10, d_val_q;
  logic                            neg_q, neg_d, d_neg_q;
  logic                            is_ws, is_dig, d_ok, c_ok, ok;
  logic [3:0]                      dig;

  assign pi      = port_i[PORT_W-1:0];
  assign port_ok = {1'b0, port_i} < (arfp_pkg::PORT_IN_W + 1)'(PORTS);

  assign cur_ph  = phase_q[pi];
  assign cur_cnt = count_q[pi];
  assign cur_cm  = comma_q[pi];
  assign full    = cur_cnt >= CNT_W'(BUF_SIZE);
  assign cnt_inc = cur_cnt + 1'b1;
  assign wr_en   = cmd_i.take && port_ok && !full;

  // frame phase update for the addressed port
  always_comb begin
    nx_ph     = cur_ph;
    nx_cnt    = cur_cnt;
    nx_cm     = cur_cm;
    need_conv = 1'b0;
    if (full) begin
      nx_ph  = arfp_pkg::PH_HDR;
      nx_cnt = '0;
      nx_cm  = '0;
    end else begin
      case (cur_ph)
        arfp_pkg::PH_HDR: begin
          if (rx_byte_i == arfp_pkg::CH_SPACE) begin
            nx_ph  = arfp_pkg::PH_DIST;
            nx_cnt = CNT_W'(1);
          end else begin
            nx_cnt = '0;
          end
        end
        arfp_pkg::PH_DIST: begin
          nx_cnt = cnt_inc;
          if (rx_byte_i == arfp_pkg::CH_COMMA) begin
            nx_ph = arfp_pkg::PH_SEP;
            nx_cm = cur_cnt[IDX_W-1:0];
          end
        end
        arfp_pkg::PH_SEP: begin
          if (rx_byte_i == arfp_pkg::CH_SPACE) begin
            nx_ph  = arfp_pkg::PH_CONF;
            nx_cnt = cnt_inc;
          end else begin
            nx_ph  = arfp_pkg::PH_HDR;
            nx_cnt = '0;
            nx_cm  = '0;
          end
        end
        default: begin
          nx_cnt = cnt_inc;
          if (rx_byte_i == arfp_pkg::CH_NEWLINE) begin
            need_conv = port_ok;
            nx_ph     = arfp_pkg::PH_HDR;
            nx_cnt    = '0;
            nx_cm     = '0;
          end
        end
      endcase
    end
  end

  // field extents: distance from index one, confidence after ", "
  assign cm1   = cur_cm - 1'b1;
  assign dlen  = (cm1 > IDX_W'(arfp_pkg::DIST_CHARS)) ? LW'(arfp_pkg::DIST_CHARS) : LW'(cm1);
  assign cbase = cur_cm + IDX_W'(2);
  assign cdiff = cur_cnt - CNT_W'(cur_cm) - CNT_W'(2);
  assign clen  = (cdiff > CNT_W'(arfp_pkg::CONF_CHARS)) ? LW'(arfp_pkg::CONF_CHARS)
                                                         : LW'(cdiff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PORTS; i++) begin
        phase_q[i] <= arfp_pkg::PH_HDR;
        count_q[i] <= '0;
        comma_q[i] <= '0;
      end
    end else if (cmd_i.take && port_ok) begin
      phase_q[pi] <= nx_ph;
      count_q[pi] <= nx_cnt;
      comma_q[pi] <= nx_cm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_min_q <= arfp_pkg::DIST_MIN_RST;
      dist_max_q <= arfp_pkg::DIST_MAX_RST;
      conf_max_q <= arfp_pkg::CONF_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        arfp_pkg::CFG_DIST_MIN: dist_min_q <= cfg_data_i[DW-1:0];
        arfp_pkg::CFG_DIST_MAX: dist_max_q <= cfg_data_i[DW-1:0];
        arfp_pkg::CFG_CONF_MAX: conf_max_q <= cfg_data_i[arfp_pkg::CONF_W-1:0];
        default: ;
      endcase
    end
  end

  // byte buffer: one write port for arriving bytes, one registered read port
  assign rd_en   = cmd_i.scan && (idx_q != len_q);
  assign rd_addr = {conv_port_q, base_q + IDX_W'(idx_q)};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[{pi, cur_cnt[IDX_W-1:0]}] <= rx_byte_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // scanner: whitespace, optional sign, then digits until a non-digit
  assign is_ws   = (rd_data_q == arfp_pkg::CH_SPACE) ||
                   ((rd_data_q >= arfp_pkg::CH_TAB) && (rd_data_q <= arfp_pkg::CH_CR));
  assign is_dig  = (rd_data_q >= arfp_pkg::CH_ZERO) && (rd_data_q <= arfp_pkg::CH_NINE);
  assign dig     = 4'(rd_data_q - arfp_pkg::CH_ZERO);
  assign acc_x10 = {acc_q[DW-4:0], 3'b000} + {acc_q[DW-2:0], 1'b0} + DW'(dig);

  always_comb begin
    sc_st_d = sc_st_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    if ((cmd_i.take && need_conv) || cmd_i.start_c) begin
      sc_st_d = arfp_pkg::SC_WS;
      acc_d   = '0;
      neg_d   = 1'b0;
    end else if (rd_pend_q) begin
      case (sc_st_q)
        arfp_pkg::SC_WS: begin
          if (is_ws) begin
            sc_st_d = arfp_pkg::SC_WS;
          end else if (rd_data_q == arfp_pkg::CH_MINUS) begin
            neg_d   = 1'b1;
            sc_st_d = arfp_pkg::SC_DIG;
          end else if (rd_data_q == arfp_pkg::CH_PLUS) begin
            sc_st_d = arfp_pkg::SC_DIG;
          end else if (is_dig) begin
            acc_d   = DW'(dig);
            sc_st_d = arfp_pkg::SC_DIG;
          end else begin
            sc_st_d = arfp_pkg::SC_STOP;
          end
        end
        arfp_pkg::SC_DIG: begin
          if (is_dig) begin
            acc_d = acc_x10;
          end else begin
            sc_st_d = arfp_pkg::SC_STOP;
          end
        end
        default: sc_st_d = arfp_pkg::SC_STOP;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_st_q   <= arfp_pkg::SC_STOP;
      idx_q     <= '0;
      len_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      sc_st_q   <= sc_st_d;
      rd_pend_q <= rd_en;
      if (cmd_i.take && need_conv) begin
        idx_q <= '0;
        len_q <= dlen;
      end else if (cmd_i.start_c) begin
        idx_q <= '0;
        len_q <= c_len_q;
      end else if (rd_en) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    neg_q <= neg_d;
    if (cmd_i.take && need_conv) begin
      conv_port_q <= pi;
      c_base_q    <= cbase;
      c_len_q     <= clen;
      base_q      <= IDX_W'(1);
    end
    if (cmd_i.start_c) begin
      d_val_q <= acc_q;
      d_neg_q <= neg_q;
      base_q  <= c_base_q;
    end
  end

  // limit check: a signed value of zero still counts as zero
  assign d_ok = !(d_neg_q && (d_val_q != '0)) && (d_val_q >= dist_min_q) &&
                (d_val_q <= dist_max_q);
  assign c_ok = !(neg_q && (acc_q != '0)) && (acc_q <= DW'(conf_max_q));
  assign ok   = d_ok && c_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_port_o   <= arfp_pkg::PORT_IN_W'(conv_port_q);
      distance_o   <= ok ? d_val_q : '0;
      confidence_o <= ok ? arfp_pkg::CONF_W'(acc_q) : '0;
      in_range_o   <= ok;
    end
  end

  assign sts_o.need_conv = need_conv;
  assign sts_o.scan_done = (idx_q == len_q) && !rd_pend_q;
  assign sts_o.out_free  = !out_valid_o || out_ready_i;

endmodule

### rtl/arfp_ctrl.sv
// ----------------------------------------------------------------------------
// arfp_ctrl
// Controller: accepts bytes, sequences the two number scans and the result.
// ----------------------------------------------------------------------------
`include "ascii_range_frame_parser_assert.svh"

module arfp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  arfp_pkg::dp_status_t  sts_i,
  output arfp_pkg::ctrl_cmd_t   cmd_o
);

  arfp_pkg::ctrl_state_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= arfp_pkg::ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      arfp_pkg::ST_IDLE: begin
        if (in_valid_i && sts_i.need_conv) begin
          st_d = arfp_pkg::ST_SCAN_D;
        end
      end
      arfp_pkg::ST_SCAN_D: begin
        if (sts_i.scan_done) begin
          st_d = arfp_pkg::ST_SCAN_C;
        end
      end
      arfp_pkg::ST_SCAN_C: begin
        if (sts_i.scan_done) begin
          st_d = arfp_pkg::ST_EMIT;
        end
      end
      arfp_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (sts_i.out_free) begin
          st_d = arfp_pkg::ST_IDLE;
        end
      end
      default: st_d = arfp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (st_q)
      arfp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      arfp_pkg::ST_SCAN_D: begin
        cmd_o.scan    = 1'b1;
        cmd_o.start_c = sts_i.scan_done;
      end
      arfp_pkg::ST_SCAN_C: begin
        cmd_o.scan = 1'b1;
      end
      arfp_pkg::ST_EMIT: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: ;
    endcase
  end

  `ARFP_ASSERT(a_conv_starts_scan, (cmd_o.take && sts_i.need_conv) |=> (st_q == arfp_pkg::ST_SCAN_D), "newline word did not start a scan")
  `ARFP_ASSERT(a_conf_after_dist, (st_q == arfp_pkg::ST_SCAN_C) |-> ($past(st_q) == arfp_pkg::ST_SCAN_D || $past(st_q) == arfp_pkg::ST_SCAN_C), "confidence scan without distance scan")
  `ARFP_ASSERT(a_emit_returns_idle, (st_q == arfp_pkg::ST_EMIT && sts_i.out_free) |=> (st_q == arfp_pkg::ST_IDLE && !cmd_o.load_out), "result load not followed by idle")
  `ARFP_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (st_q == arfp_pkg::ST_IDLE && !cmd_o.scan), "controller busy in reset")

endmodule

### rtl/ascii_range_frame_parser.sv
// ----------------------------------------------------------------------------
// ascii_range_frame_parser
// Per-port parser for " <distance>, <confidence>\n" rangefinder text frames.
// ----------------------------------------------------------------------------
//  channel  dir  handshake    payload
//  in_if    in   valid/ready  port[2:0], rx_byte[7:0]
//  out_if   out  valid/ready  out_port[2:0], distance[16:0], confidence[6:0], in_range
//  cfg      in   cfg_we_i     cfg_idx_i[1:0], cfg_data_i[16:0]
//
//  Every byte except a frame-closing newline is accepted while the controller
//  stays idle. A closing newline is accepted, then holds the input while the
//  single buffer read port walks the stored characters one per cycle through a
//  shared decimal scanner, first for the distance field and then for the
//  confidence field, and until the result is loaded into the result register.
//  Reset clears all port phases and counts and loads the default limits;
//  the byte buffer is not cleared, so no clearing pass runs.
//  The result register holds a word under stall; bytes keep flowing while it
//  waits, but a closing newline then holds the input until the register frees.
// ----------------------------------------------------------------------------
module ascii_range_frame_parser #(
  parameter int PORTS    = 2,
  parameter int BUF_SIZE = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  arfp_in_if.sink                          in_if,
  arfp_out_if.source                       out_if,
  input  logic                             cfg_we_i,
  input  logic [arfp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [arfp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  arfp_pkg::ctrl_cmd_t  cmd;
  arfp_pkg::dp_status_t sts;
  logic                 in_ready;

  assign in_if.ready = in_ready;

  arfp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  arfp_dp #(
    .PORTS    (PORTS),
    .BUF_SIZE (BUF_SIZE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .port_i       (in_if.port),
    .rx_byte_i    (in_if.rx_byte),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_port_o   (out_if.out_port),
    .distance_o   (out_if.distance),
    .confidence_o (out_if.confidence),
    .in_range_o   (out_if.in_range)
  );

endmodule

### dv/arfp_frame_checker.sv
// ----------------------------------------------------------------------------
// arfp_frame_checker
// Watches the byte, result and limit-write ports of the frame parser. Keeps
// its own per-port parse state and limits, predicts the range word for every
// closed frame and compares each result word field by field.
// ----------------------------------------------------------------------------
module arfp_frame_checker
  import arfp_pkg::*;
#(
  parameter int PORTS    = 2,
  parameter int BUF_SIZE = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  arfp_in_if                    byte_mon,
  arfp_out_if                   range_mon,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_cnt_o,
  output int                    pending_o,
  output int                    checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PORT_IN_W-1:0] port;
    logic [DIST_W-1:0]    distance;
    logic [CONF_W-1:0]    confidence;
    logic                 in_range;
  } range_word_t;

  range_word_t       range_expect_q [$];
  phase_e            ph_q    [PORTS];
  int                fill_q  [PORTS];
  int                comma_q [PORTS];
  logic [BYTE_W-1:0] text_q  [PORTS][BUF_SIZE];
  logic [DIST_W-1:0] dist_min_q;
  logic [DIST_W-1:0] dist_max_q;
  logic [CONF_W-1:0] conf_max_q;
  int                mismatch_cnt = 0;
  int                checked_cnt  = 0;
  int                pending_cnt  = 0;

  assign fail_cnt_o = mismatch_cnt;
  assign pending_o  = pending_cnt;
  assign checked_o  = checked_cnt;

  function automatic void note_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("[%0t] %s", $time, msg);
    end
  endfunction

  function automatic void clear_port(int p);
    ph_q[p]    = PH_HDR;
    fill_q[p]  = 0;
    comma_q[p] = 0;
  endfunction

  // Decimal text to integer, C style: blanks, one sign, then digits.
  function automatic int atoi_field(int p, int start, int len);
    int                i;
    bit                neg;
    int                val;
    logic [BYTE_W-1:0] c;
    i   = 0;
    neg = 1'b0;
    val = 0;
    while (i < len) begin
      c = text_q[p][(start + i) % BUF_SIZE];
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        i++;
      end else begin
        break;
      end
    end
    if (i < len) begin
      c = text_q[p][(start + i) % BUF_SIZE];
      if (c == CH_MINUS) begin
        neg = 1'b1;
        i++;
      end else if (c == CH_PLUS) begin
        i++;
      end
    end
    while (i < len) begin
      c = text_q[p][(start + i) % BUF_SIZE];
      if (c < CH_ZERO || c > CH_NINE) begin
        break;
      end
      val = val * 10 + (int'(c) - int'(CH_ZERO));
      i++;
    end
    return neg ? -val : val;
  endfunction

  function automatic void predict_byte(int p, logic [BYTE_W-1:0] b);
    int          dlen;
    int          cstart;
    int          clen;
    int          dist_val;
    int          conf_val;
    bit          ok;
    range_word_t w;
    if (p >= PORTS) begin
      return;
    end
    // A full buffer drops the word and restarts the port.
    if (fill_q[p] >= BUF_SIZE) begin
      clear_port(p);
      return;
    end
    text_q[p][fill_q[p]] = b;
    fill_q[p]++;
    case (ph_q[p])
      PH_HDR: begin
        if (b == CH_SPACE) begin
          ph_q[p]   = PH_DIST;
          fill_q[p] = 1;
        end else begin
          fill_q[p] = 0;
        end
        return;
      end
      PH_DIST: begin
        if (b == CH_COMMA) begin
          ph_q[p]    = PH_SEP;
          comma_q[p] = fill_q[p] - 1;
        end
        return;
      end
      PH_SEP: begin
        if (b == CH_SPACE) begin
          ph_q[p] = PH_CONF;
        end else begin
          clear_port(p);
        end
        return;
      end
      default: ;
    endcase
    if (b != CH_NEWLINE) begin
      return;
    end
    dlen = (comma_q[p] >= 1) ? comma_q[p] - 1 : 0;
    if (dlen > DIST_CHARS) begin
      dlen = DIST_CHARS;
    end
    cstart = comma_q[p] + 2;
    clen   = (fill_q[p] >= cstart + 1) ? fill_q[p] - cstart - 1 : 0;
    if (clen > CONF_CHARS) begin
      clen = CONF_CHARS;
    end
    dist_val = atoi_field(p, 1, dlen);
    conf_val = atoi_field(p, cstart, clen);
    ok = dist_val >= int'(dist_min_q) && dist_val <= int'(dist_max_q) &&
         conf_val >= 0 && conf_val <= int'(conf_max_q);
    clear_port(p);
    w.port       = p[PORT_IN_W-1:0];
    w.distance   = ok ? dist_val[DIST_W-1:0] : '0;
    w.confidence = ok ? conf_val[CONF_W-1:0] : '0;
    w.in_range   = ok;
    range_expect_q.push_back(w);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    range_word_t want;
    if (!rst_ni) begin
      for (int p = 0; p < PORTS; p++) begin
        clear_port(p);
      end
      dist_min_q = DIST_MIN_RST;
      dist_max_q = DIST_MAX_RST;
      conf_max_q = CONF_MAX_RST;
      range_expect_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_DIST_MIN: dist_min_q = cfg_data_i[DIST_W-1:0];
          CFG_DIST_MAX: dist_max_q = cfg_data_i[DIST_W-1:0];
          CFG_CONF_MAX: conf_max_q = cfg_data_i[CONF_W-1:0];
          default: ;
        endcase
      end
      if (range_mon.valid && range_mon.ready) begin
        if (range_expect_q.size() == 0) begin
          note_mismatch($sformatf("unexpected range word: port %0d dist %0d conf %0d ok %0b",
                                  range_mon.out_port, range_mon.distance,
                                  range_mon.confidence, range_mon.in_range));
        end else begin
          want = range_expect_q.pop_front();
          checked_cnt++;
          if (range_mon.out_port !== want.port || range_mon.distance !== want.distance ||
              range_mon.confidence !== want.confidence ||
              range_mon.in_range !== want.in_range) begin
            note_mismatch($sformatf(
              "range word mismatch: expected port %0d dist %0d conf %0d ok %0b, got port %0d dist %0d conf %0d ok %0b",
              want.port, want.distance, want.confidence, want.in_range,
              range_mon.out_port, range_mon.distance, range_mon.confidence,
              range_mon.in_range));
          end
        end
      end
      if (byte_mon.valid && byte_mon.ready) begin
        predict_byte(int'(byte_mon.port), byte_mon.rx_byte);
      end
    end
    pending_cnt = range_expect_q.size();
  end

endmodule

### dv/ascii_range_frame_parser_tb.sv
// ----------------------------------------------------------------------------
// ascii_range_frame_parser_tb
// Drives rangefinder text frames into the parser over several limit settings:
// a few hand-made frames, then interleaved random frames on both ports with
// broken headers, bad separators, signs, blanks, truncation and buffer
// overflow, plus stray bytes on unused ports. Both channels stall at random;
// one long output stall backs the parser up. Checking is in arfp_frame_checker.
// ----------------------------------------------------------------------------
module ascii_range_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import arfp_pkg::*;

  localparam int PORTS           = 2;
  localparam int BUF_SIZE        = 32;
  localparam int BYTES_PER_PHASE = 160;
  localparam int LIMIT_PHASES    = 6;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 20;
  localparam int TAIL_CYCLES     = 30;

  typedef logic [BYTE_W-1:0] byte_text_t [$];

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int fail_cnt;
  int pending_cnt;
  int checked_cnt;
  int active_bytes = 0;
  bit idle_on      = 1'b1;
  bit hold_req     = 1'b0;

  arfp_in_if  byte_ch ();
  arfp_out_if range_ch ();

  ascii_range_frame_parser #(
    .PORTS   (PORTS),
    .BUF_SIZE(BUF_SIZE)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (byte_ch),
    .out_if    (range_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  arfp_frame_checker #(
    .PORTS   (PORTS),
    .BUF_SIZE(BUF_SIZE)
  ) frame_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_mon  (byte_ch),
    .range_mon (range_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending_cnt),
    .checked_o (checked_cnt)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold on request.
  initial begin
    int stall_left;
    stall_left = 0;
    range_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        range_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD - 1;
        range_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 11);
        range_ch.ready <= 1'b0;
      end else begin
        range_ch.ready <= 1'b1;
      end
    end
  end

  task automatic offer_byte(int p, logic [BYTE_W-1:0] b);
    if (idle_on && $urandom_range(0, 11) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.port    <= p[PORT_IN_W-1:0];
    byte_ch.rx_byte <= b;
    do @(posedge clk_i); while (byte_ch.ready !== 1'b1);
    if (p < PORTS) begin
      active_bytes++;
    end
  endtask

  task automatic send_text(int p, string s);
    for (int i = 0; i < s.len(); i++) begin
      offer_byte(p, s[i]);
    end
  endtask

  // Drop valid and hold until every predicted word has come out.
  task automatic quiet_and_drain();
    byte_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  task automatic write_limits(int dmin, int dmax, int cmax);
    quiet_and_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_DIST_MIN;
    cfg_data_i <= dmin[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= CFG_DIST_MAX;
    cfg_data_i <= dmax[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CONF_MAX;
    cfg_data_i <= cmax[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic byte_text_t digit_run(int n);
    byte_text_t t;
    for (int i = 0; i < n; i++) begin
      t.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    return t;
  endfunction

  function automatic byte_text_t junk_run(int n, logic [BYTE_W-1:0] banned);
    byte_text_t        t;
    logic [BYTE_W-1:0] b;
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom_range(0, 255)); while (b == banned);
      t.push_back(b);
    end
    return t;
  endfunction

  // Leading blank other than newline, so it never closes a frame.
  function automatic logic [BYTE_W-1:0] blank_char();
    case ($urandom_range(0, 4))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_TAB + 8'd2;
      3:       return CH_TAB + 8'd3;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] sign_char();
    return $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
  endfunction

  function automatic byte_text_t distance_text();
    byte_text_t t;
    int         kind;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      t = digit_run($urandom_range(1, DIST_CHARS));
    end else if (kind < 58) begin
      repeat ($urandom_range(1, 2)) t.push_back(blank_char());
      t = {t, digit_run($urandom_range(1, 3))};
    end else if (kind < 70) begin
      t.push_back(sign_char());
      t = {t, digit_run($urandom_range(0, 4))};
    end else if (kind < 78) begin
      t = digit_run($urandom_range(6, 8));
    end else if (kind < 83) begin
      t.delete();
    end else if (kind < 93) begin
      t = junk_run($urandom_range(1, 6), CH_COMMA);
    end else begin
      // long enough to run the buffer full
      t = junk_run($urandom_range(28, 34), CH_COMMA);
    end
    return t;
  endfunction

  function automatic byte_text_t confidence_text();
    byte_text_t t;
    int         kind;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      t = digit_run($urandom_range(1, CONF_CHARS));
    end else if (kind < 58) begin
      t.push_back(blank_char());
      t = {t, digit_run(1)};
    end else if (kind < 70) begin
      t.push_back(sign_char());
      t = {t, digit_run($urandom_range(0, 2))};
    end else if (kind < 78) begin
      t = digit_run($urandom_range(3, 4));
    end else if (kind < 83) begin
      t.delete();
    end else if (kind < 93) begin
      t = junk_run($urandom_range(1, 3), CH_NEWLINE);
    end else begin
      t = digit_run($urandom_range(26, 32));
    end
    return t;
  endfunction

  function automatic byte_text_t frame_text();
    byte_text_t t;
    int         shape;
    shape = $urandom_range(0, 99);
    if (shape < 6) begin
      t = junk_run($urandom_range(1, 3), CH_SPACE);
    end
    t.push_back(CH_SPACE);
    t = {t, distance_text()};
    t.push_back(CH_COMMA);
    if (shape >= 94) begin
      t = {t, junk_run(1, CH_SPACE)};
    end else begin
      t.push_back(CH_SPACE);
    end
    t = {t, confidence_text()};
    t.push_back(CH_NEWLINE);
    return t;
  endfunction

  // Two frames, interleaved word by word when on different ports.
  task automatic send_frame_pair();
    byte_text_t a;
    byte_text_t b;
    int         pa;
    int         pb;
    pa = $urandom_range(0, PORTS - 1);
    pb = $urandom_range(0, PORTS - 1);
    a  = frame_text();
    b  = frame_text();
    if (pa == pb) begin
      a = {a, b};
      b.delete();
    end
    while (a.size() > 0 || b.size() > 0) begin
      if (PORTS < 8 && $urandom_range(0, 24) == 0) begin
        offer_byte($urandom_range(PORTS, 7), 8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 49) == 0) begin
        offer_byte(pa, 8'($urandom_range(0, 255)));
      end else if (a.size() > 0 && (b.size() == 0 || $urandom_range(0, 1) == 1)) begin
        offer_byte(pa, a.pop_front());
      end else begin
        offer_byte(pb, b.pop_front());
      end
    end
  endtask

  initial begin
    int dmin;
    int stop_at;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_DIST_MIN;
    cfg_data_i      <= '0;
    byte_ch.valid   <= 1'b0;
    byte_ch.port    <= '0;
    byte_ch.rx_byte <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hand-made frames under the reset limits.
    send_text(1, " 99999, 99\n");
    send_text(0, " 0, 0\n");
    if (PORTS < 8) begin
      offer_byte(7, 8'hFF);
    end
    offer_byte(0, 8'h00);
    send_text(0, " -5,x");

    for (int ph = 0; ph < LIMIT_PHASES; ph++) begin
      case (ph)
        0: write_limits(0, 99999, 99);
        1: write_limits(0, 0, 0);
        2: write_limits(99999, 99999, 99);
        3: begin
          dmin = $urandom_range(0, 999);
          write_limits(dmin, $urandom_range(dmin, 99999), $urandom_range(0, 99));
        end
        4: write_limits($urandom_range(50000, 99999), $urandom_range(0, 49999), 99);
        default: write_limits(0, $urandom_range(10000, 99999), $urandom_range(10, 99));
      endcase
      // Back the parser up while frames keep coming.
      if (ph == 2) begin
        hold_req = 1'b1;
      end
      if (ph == LIMIT_PHASES - 1) begin
        idle_on = 1'b0;
      end
      stop_at = active_bytes + BYTES_PER_PHASE;
      while (active_bytes < stop_at) begin
        send_frame_pair();
      end
    end

    quiet_and_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Summary: %0d bytes on live ports, %0d range words checked, %0d limit settings",
             active_bytes, checked_cnt, LIMIT_PHASES);
    $display("Summary: framing errors, buffer overflow, signs, blanks, truncation, %0d-cycle stall",
             LONG_HOLD);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
